>>> src/ycc2rgb_pkg.sv
// Shared types and constants for the YCbCr to RGB565/RGB555 pixel converter.
package ycc2rgb_pkg;

   typedef logic signed [7:0] sample_type;
   typedef logic [15:0]       pixel_type;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LUMA_ONLY    = 1'd1;

   // pixel_format codes
   localparam logic FMT_RGB565 = 1'b0;
   localparam logic FMT_RGB555 = 1'b1;

   // chroma terms: red from Cr, green from Cb, green from Cr, blue from Cb
   localparam int N_TERMS       = 4;
   localparam int TERM_CR_RED   = 0;
   localparam int TERM_CB_GREEN = 1;
   localparam int TERM_CR_GREEN = 2;
   localparam int TERM_CB_BLUE  = 3;

   localparam int KPROD_W = 26;   // K*c + scale, signed
   localparam int MAG_W   = 25;   // |K*c + scale| < 2^25
   localparam int QUO_W   = 8;    // |quotient| <= 226
   localparam int TERM_W  = 9;    // signed quotient
   localparam int SUM_W   = 10;   // term + half luma, signed
   localparam int CH_W    = 7;    // clamped channel 0..127

   localparam logic signed [KPROD_W-1:0] K_TERM [N_TERMS] = '{
      26'sd140200, -26'sd34414, -26'sd71414, 26'sd177200
   };
   localparam logic [N_TERMS-1:0] TERM_USES_CR = 4'b0101;
   localparam logic signed [KPROD_W-1:0] K_SCALE = 26'sd100000;

   // floor(n / 100000) = (n * RECIP_M) >> RECIP_SHIFT, exact for n < 2^25
   localparam int RECIP_W     = 26;
   localparam int RECIP_SHIFT = 42;
   localparam int RPROD_W     = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_M = 26'd43980466;

endpackage

>>> src/ycc2rgb_req_if.sv
// Input channel: one level-shifted YCbCr pixel per transfer.
interface ycc2rgb_req_if import ycc2rgb_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type luma;
   sample_type chroma_blue;
   sample_type chroma_red;

   modport source (output valid, luma, chroma_blue, chroma_red, input ready);
   modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

>>> src/ycc2rgb_rsp_if.sv
// Result channel: one packed 16-bit pixel per transfer.
interface ycc2rgb_rsp_if import ycc2rgb_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, pixel, input ready);
   modport sink   (input valid, pixel, output ready);
endinterface

>>> src/ycbcr_to_rgb16_pixel.sv
// YCbCr to RGB565/RGB555 converter: five-stage pipeline, one pixel per clock while the result side is ready.
// rsp valid is the valid bit of the last stage, the output register that holds the packed pixel.
// Throughput: one pixel per clock while the result side is ready; the slowest stage is the 25x26 reciprocal multiply.
// Backpressure stalls only the stages behind a full one; bubbles are squeezed out.
// Reset (synchronous, active high) clears all stage valid bits and both config
// registers (RGB565, color mode); no clearing pass, ready right after reset.
module ycbcr_to_rgb16_pixel import ycc2rgb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ycc2rgb_req_if.sink            req_ch,
   ycc2rgb_rsp_if.source          rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int N_STAGES = 5;

   // config registers; the user must write them only while the pipe is empty, the block does not enforce it
   logic pixel_format_ff;
   logic luma_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RGB565;
         luma_only_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_wdata[0];
            CSR_LUMA_ONLY:    luma_only_ff    <= csr_wdata[0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage control. A stage loads when it is empty or its contents move on;
   // the last stage is the output register.
   // ---------------------------------------------------------------------
   logic [N_STAGES-1:0] vld_ff;
   logic [N_STAGES-1:0] vld_in;
   logic [N_STAGES-1:0] en;

   always_comb begin
      en[N_STAGES-1] = !vld_ff[N_STAGES-1] || rsp_ch.ready;
      for (int k = N_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      if (en[0]) begin
         vld_in[0] = req_ch.valid;
      end else begin
         vld_in[0] = vld_ff[0];
      end
      for (int k = 1; k < N_STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = en[0];

   // ---------------------------------------------------------------------
   // Stage 1: p = K*c + scale for the four chroma terms. u = Y + 128.
   // ---------------------------------------------------------------------
   logic signed [KPROD_W-1:0] prod_in [N_TERMS];
   logic signed [KPROD_W-1:0] prod_ff [N_TERMS];
   logic [7:0]                u1_ff;

   always_comb begin
      for (int i = 0; i < N_TERMS; i++) begin
         prod_in[i] = K_TERM[i] * KPROD_W'(TERM_USES_CR[i] ? req_ch.chroma_red
                                                            : req_ch.chroma_blue)
                      + K_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         u1_ff   <= {~req_ch.luma[7], req_ch.luma[6:0]};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: sign and magnitude, so the divide can truncate toward zero.
   // ---------------------------------------------------------------------
   logic [MAG_W-1:0]          mag_in [N_TERMS];
   logic signed [KPROD_W-1:0] abs_v  [N_TERMS];
   logic [MAG_W-1:0]          mag_ff [N_TERMS];
   logic [N_TERMS-1:0]        neg2_ff;
   logic [7:0]                u2_ff;

   always_comb begin
      for (int i = 0; i < N_TERMS; i++) begin
         abs_v[i]  = prod_ff[i][KPROD_W-1] ? -prod_ff[i] : prod_ff[i];
         mag_in[i] = abs_v[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mag_ff <= mag_in;
         for (int i = 0; i < N_TERMS; i++) begin
            neg2_ff[i] <= prod_ff[i][KPROD_W-1];
         end
         u2_ff <= u1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: |p| / 100000 by reciprocal multiply.
   // ---------------------------------------------------------------------
   logic [RPROD_W-1:0] rprod  [N_TERMS];
   logic [QUO_W-1:0]   quo_in [N_TERMS];
   logic [QUO_W-1:0]   quo_ff [N_TERMS];
   logic [N_TERMS-1:0] neg3_ff;
   logic [7:0]         u3_ff;

   always_comb begin
      for (int i = 0; i < N_TERMS; i++) begin
         rprod[i]  = RPROD_W'(mag_ff[i]) * RPROD_W'(RECIP_M);
         quo_in[i] = rprod[i][RECIP_SHIFT +: QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         quo_ff  <= quo_in;
         neg3_ff <= neg2_ff;
         u3_ff   <= u2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: restore sign, halve with floor, add half-scale luma.
   // ---------------------------------------------------------------------
   logic signed [TERM_W-1:0] q_s  [N_TERMS];
   logic signed [TERM_W-2:0] t_s  [N_TERMS];
   logic signed [SUM_W-1:0]  half_luma;
   logic signed [SUM_W-1:0]  sum_r_in, sum_g_in, sum_b_in;
   logic signed [SUM_W-1:0]  sum_r_ff, sum_g_ff, sum_b_ff;
   logic [7:0]               u4_ff;

   always_comb begin
      for (int i = 0; i < N_TERMS; i++) begin
         q_s[i] = neg3_ff[i] ? -$signed({1'b0, quo_ff[i]}) : $signed({1'b0, quo_ff[i]});
         t_s[i] = q_s[i][TERM_W-1:1];   // arithmetic shift right by one
      end
      half_luma = $signed({3'b000, u3_ff[7:1]});
      sum_r_in  = SUM_W'(t_s[TERM_CR_RED]) + half_luma;
      sum_g_in  = SUM_W'(t_s[TERM_CB_GREEN]) + SUM_W'(t_s[TERM_CR_GREEN]) + half_luma;
      sum_b_in  = SUM_W'(t_s[TERM_CB_BLUE]) + half_luma;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
         u4_ff    <= u3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5 (output register): clamp to 0..127 and pack, or pack the luma alone in luma-only mode.
   // ---------------------------------------------------------------------
   function automatic logic [CH_W-1:0] clamp7(input logic signed [SUM_W-1:0] v);
      logic [CH_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > SUM_W'(127)) begin
         res = '1;
      end else begin
         res = v[CH_W-1:0];
      end
      return res;
   endfunction

   logic [CH_W-1:0] ch_r, ch_g, ch_b;
   pixel_type       pixel_in;
   pixel_type       pixel_ff;

   always_comb begin
      ch_r = clamp7(sum_r_ff);
      ch_g = clamp7(sum_g_ff);
      ch_b = clamp7(sum_b_ff);
      unique case ({luma_only_ff, pixel_format_ff})
         {1'b0, FMT_RGB565}: pixel_in = {ch_r[6:2], ch_g[6:1], ch_b[6:2]};
         {1'b0, FMT_RGB555}: pixel_in = {1'b0, ch_r[6:2], ch_g[6:2], ch_b[6:2]};
         {1'b1, FMT_RGB565}: pixel_in = {u4_ff[7:3], u4_ff[7:2], u4_ff[7:3]};
         {1'b1, FMT_RGB555}: pixel_in = {1'b0, u4_ff[7:3], u4_ff[7:3], u4_ff[7:3]};
         default:            pixel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_ch.valid = vld_ff[N_STAGES-1];
   assign rsp_ch.pixel = pixel_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a ready sink downstream must never stall the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while result side is ready");

   // with rsp ready held after an input transfer, the pixel reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) ##1 rsp_ch.ready ##1 rsp_ch.ready
         ##1 rsp_ch.ready ##1 rsp_ch.ready |=> rsp_ch.valid)
      else $error("pixel lost in pipeline");

   // RGB555 leaves the top bit clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && pixel_format_ff == FMT_RGB555) |-> !rsp_ch.pixel[15])
      else $error("bit 15 set in RGB555 pixel");

endmodule

>>> sim/ycbcr_to_rgb16_pixel_tb.sv
// Self-checking testbench for the YCbCr to RGB565/RGB555 pixel converter.
`timescale 1ns / 100ps

module ycbcr_to_rgb16_pixel_tb import ycc2rgb_pkg::*;;

   // One expected output pixel, with the input that produced it for messages.
   typedef struct {
      pixel_type  pixel;
      sample_type luma;
      sample_type cb;
      sample_type cr;
   } pending_pixel_type;

   // Predicts each output pixel from the current register settings and
   // compares the pixels that come out against them, oldest first.
   class rgb16_scoreboard;
      localparam int CR_TO_RED    = 140200;
      localparam int CB_TO_GREEN  = -34414;
      localparam int CR_TO_GREEN  = -71414;
      localparam int CB_TO_BLUE   = 177200;
      localparam int CHROMA_SCALE = 100000;

      logic              fmt;
      logic              gray;
      pending_pixel_type pending_pixels[$];
      int                fail_count;

      function new();
         fmt        = FMT_RGB565;
         gray       = 1'b0;
         fail_count = 0;
      endfunction

      // trunc((k*c + scale) / scale), then floor of half
      function int chroma_part(int k, int c);
         int q;
         q = (k * c + CHROMA_SCALE) / CHROMA_SCALE;
         return q >>> 1;
      endfunction

      function logic [6:0] clamp_channel(int v);
         if (v < 0) return 7'd0;
         if (v > 127) return 7'd127;
         return v[6:0];
      endfunction

      function pixel_type convert_pixel(sample_type y, sample_type cb, sample_type cr);
         logic [7:0] u;
         logic [6:0] r;
         logic [6:0] g;
         logic [6:0] b;
         int         h;
         u = y ^ 8'h80;   // Y + 128
         if (gray) begin
            if (fmt == FMT_RGB555)
               return {1'b0, u[7:3], u[7:3], u[7:3]};
            return {u[7:3], u[7:2], u[7:3]};
         end
         h = int'(u >> 1);
         r = clamp_channel(h + chroma_part(CR_TO_RED, int'(cr)));
         g = clamp_channel(h + chroma_part(CB_TO_GREEN, int'(cb))
                             + chroma_part(CR_TO_GREEN, int'(cr)));
         b = clamp_channel(h + chroma_part(CB_TO_BLUE, int'(cb)));
         if (fmt == FMT_RGB555)
            return {1'b0, r[6:2], g[6:2], b[6:2]};
         return {r[6:2], g[6:1], b[6:2]};
      endfunction

      task report(string what);
         $display("%0t ns: MISMATCH %s", $time, what);
         fail_count++;
      endtask

      function void note_pixel_in(sample_type y, sample_type cb, sample_type cr);
         pending_pixel_type p;
         p.pixel = convert_pixel(y, cb, cr);
         p.luma  = y;
         p.cb    = cb;
         p.cr    = cr;
         pending_pixels.push_back(p);
      endfunction

      task check_pixel_out(pixel_type got);
         pending_pixel_type p;
         if (pending_pixels.size() == 0) begin
            report($sformatf("pixel %h arrived with nothing pending", got));
            return;
         end
         p = pending_pixels.pop_front();
         if (got !== p.pixel)
            report($sformatf("pixel got %h want %h (Y %0d Cb %0d Cr %0d fmt %0d gray %0d)",
                             got, p.pixel, p.luma, p.cb, p.cr, fmt, gray));
      endtask
   endclass

   localparam int N_PHASES     = 8;
   localparam int RANDOM_ITEMS = 88;    // per phase
   localparam int SETTLE_CYC   = 8;     // pipeline is 5 deep
   localparam int DRAIN_LIMIT  = 2000;
   localparam int IDLE_PCT     = 21;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic calm;   // set for a stretch where neither side idles

   rgb16_scoreboard pix_board;

   ycc2rgb_req_if req_bus ();
   ycc2rgb_rsp_if rsp_bus ();

   ycbcr_to_rgb16_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Hard stop; a correct run ends in a small fraction of this.
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: check each transfer, then pick ready for the next cycle.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            pix_board.check_pixel_out(rsp_bus.pixel);
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Write both registers, one per cycle. Call only with the pipeline empty.
   task automatic apply_setting(logic fmt, logic gray);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PIXEL_FORMAT;
      csr_wdata <= fmt;
      @(posedge clock);
      csr_index <= CSR_LUMA_ONLY;
      csr_wdata <= gray;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pix_board.fmt  = fmt;
      pix_board.gray = gray;
   endtask

   // Offer one pixel, with random idle cycles in front, and hold it until the
   // transfer. Valid stays high afterwards; the caller or the next gap drops it.
   task automatic send_pixel(sample_type y, sample_type cb, sample_type cr);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.luma        <= y;
      req_bus.chroma_blue <= cb;
      req_bus.chroma_red  <= cr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pix_board.note_pixel_in(y, cb, cr);
   endtask

   // Bias toward the extremes and small values near zero.
   function automatic sample_type pick_sample();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return -8'sd128;
      if (sel == 1) return 8'sd127;
      if (sel == 2) return 8'sd0;
      if (sel == 3) return sample_type'($urandom_range(0, 16) - 8);
      return sample_type'($urandom_range(0, 255));
   endfunction

   // Directed pixels: all corners of the input cube in the first setting, four
   // each in the next three, none after. Corners drive channels past both clamps.
   task automatic send_directed(int phase);
      sample_type lo;
      sample_type hi;
      lo = -8'sd128;
      hi = 8'sd127;
      if (phase == 0) begin
         for (int i = 0; i < 8; i++)
            send_pixel(i[0] ? hi : lo, i[1] ? hi : lo, i[2] ? hi : lo);
         send_pixel(8'sd0, 8'sd0, 8'sd0);
         send_pixel(-8'sd1, -8'sd1, -8'sd1);
         send_pixel(8'sd64, -8'sd40, 8'sd90);
         send_pixel(-8'sd100, 8'sd100, -8'sd100);
      end else if (phase < 4) begin
         send_pixel(lo, hi, lo);
         send_pixel(hi, lo, hi);
         send_pixel(8'sd0, lo, hi);
         send_pixel(8'sd5, hi, lo);
      end
   endtask

   task automatic wait_for_drain();
      int guard;
      guard = 0;
      while (pix_board.pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      pix_board           = new();
      reset               = 1'b1;
      calm                = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_PIXEL_FORMAT;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.luma        = '0;
      req_bus.chroma_blue = '0;
      req_bus.chroma_red  = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // First four phases walk every register combination, the rest pick one
      // at random. Phase 5 runs with no idling on either side.
      for (int phase = 0; phase < N_PHASES; phase++) begin
         logic fmt;
         logic gray;
         if (phase < 4) begin
            fmt  = phase[0] ? FMT_RGB555 : FMT_RGB565;
            gray = phase[1];
         end else begin
            fmt  = $urandom_range(0, 1) ? FMT_RGB555 : FMT_RGB565;
            gray = 1'($urandom_range(0, 1));
         end
         apply_setting(fmt, gray);
         calm <= (phase == 5);
         send_directed(phase);
         for (int n = 0; n < RANDOM_ITEMS; n++)
            send_pixel(pick_sample(), pick_sample(), pick_sample());
         req_bus.valid <= 1'b0;
         wait_for_drain();
      end

      // Anything still pending here never came out.
      if (pix_board.pending_pixels.size() != 0)
         pix_board.report($sformatf("%0d pixels never arrived",
                                    pix_board.pending_pixels.size()));

      if (pix_board.fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
